### rtl/mpds_pkg.sv
`default_nettype none
package mpds_pkg;
   localparam int DUTY_FRAC_BITS_DEF = 16;
   localparam int TICK_BITS_DEF = 16;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 16;
   localparam int TICK_MIN_US = 100;
   localparam int TICK_MAX_US = 20000;
   localparam int Q15_MILLI = 33;
   localparam int Q15_ONE = 32768;
   localparam int CHARGE_FRAC = 8;
   localparam int DIV_BITS = 40;

   localparam logic [2:0] CSR_MIN_DUTY = 3'd0;
   localparam logic [2:0] CSR_MAX_DUTY = 3'd1;
   localparam logic [2:0] CSR_DEADBAND = 3'd2;
   localparam logic [2:0] CSR_LIN_START = 3'd3;
   localparam logic [2:0] CSR_NEAR_CAP = 3'd4;
   localparam logic [2:0] CSR_PULSE_W = 3'd5;
   localparam logic [2:0] CSR_REV_COAST = 3'd6;

   localparam logic [2:0] MODE_IDLE = 3'd0;
   localparam logic [2:0] MODE_REVERSE = 3'd1;
   localparam logic [2:0] MODE_CONT = 3'd2;
   localparam logic [2:0] MODE_PULSE_ON = 3'd3;
   localparam logic [2:0] MODE_PULSE_OFF = 3'd4;

   typedef struct packed {
      logic load;      // latch item, compute front end
      logic div1_start;
      logic div2_start;
      logic finish;    // commit state, load result
   } cmd_type;

   typedef struct packed {
      logic early_done; // result already decided without division
      logic need_div2;
      logic div_busy;
   } sts_type;
endpackage
`default_nettype wire

### rtl/mpds_div.sv
`default_nettype none
module mpds_div (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic [mpds_pkg::DIV_BITS-1:0] num,
   input  wire logic [16:0] den,
   output logic busy,
   output logic [mpds_pkg::DIV_BITS-1:0] quo
);
   import mpds_pkg::*;
   logic [DIV_BITS-1:0] q_ff, q_in;
   logic [17:0] r_ff, r_in;
   logic [16:0] d_ff, d_in;
   logic [5:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic [17:0] trial;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; cnt_in = cnt_ff; busy_in = busy_ff;
      trial = {r_ff[16:0], q_ff[DIV_BITS-1]};
      if (start) begin
         q_in = num; r_in = '0; d_in = den; cnt_in = 6'(DIV_BITS); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[DIV_BITS-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[DIV_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; cnt_ff <= cnt_in;
      end
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in;
   end
   assign busy = busy_ff;
   assign quo = q_ff;
endmodule
`default_nettype wire

### rtl/mpds_datapath.sv
`default_nettype none
module mpds_datapath #(
   parameter int TICK_BITS = mpds_pkg::TICK_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire mpds_pkg::cmd_type cmd,
   output mpds_pkg::sts_type sts,
   input  wire logic csr_write,
   input  wire logic [mpds_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [mpds_pkg::CSR_DATA_BITS-1:0] csr_data,
   input  wire logic req_operation,
   input  wire logic signed [15:0] req_command,
   input  wire logic req_near_balance,
   input  wire logic [TICK_BITS-1:0] req_tick_us,
   output logic signed [16:0] res_duty,
   output logic [2:0] res_mode
);
   import mpds_pkg::*;
   logic [15:0] min_ff, max_ff, cap_ff, pw_ff, rc_ff;
   logic [14:0] db_ff, ls_ff;
   logic [31:0] charge_ff;
   logic [15:0] prem_ff, coast_ff;
   logic [1:0] ldir_ff;
   logic [14:0] absu_ff;
   logic [15:0] lin_ff;
   logic [14:0] dt_ff;
   logic neg_ff, near_ff, early_ff, div2_ff, lowseg_ff;
   logic signed [16:0] duty_ff;
   logic [2:0] mode_ff;
   logic [16:0] req_ff;

   logic signed [16:0] c;
   logic [14:0] absu;
   logic [15:0] lin, lin0;
   logic [TICK_BITS-1:0] dtc;
   logic [14:0] dt;
   logic neg;
   logic [1:0] dirc;
   logic [16:0] den_lin;
   logic [15:0] num_lin;
   logic signed [17:0] span;
   logic [DIV_BITS-1:0] dnum;
   logic [16:0] dden;
   logic busy;
   logic [DIV_BITS-1:0] quo;
   logic [16:0] req_a, req_b, capv;
   logic signed [18:0] req_s;
   logic [32:0] csum;
   logic [31:0] csat;
   logic [23:0] pwq;
   logic [15:0] prem_new;

   assign c = 17'(req_command);
   always_comb begin
      absu = (c < 0) ? ((c == -17'sd32768) ? 15'h7FFF : 15'(-c)) : 15'(c);
      neg = !(c > 0);
      dirc = neg ? 2'd2 : 2'd1;
      lin0 = 16'(db_ff) + 16'(Q15_MILLI);
      lin = (16'(ls_ff) > lin0) ? 16'(ls_ff) : lin0;
      dtc = req_tick_us;
      if (32'(dtc) < 32'(TICK_MIN_US)) dt = 15'(TICK_MIN_US);
      else if (32'(dtc) > 32'(TICK_MAX_US)) dt = 15'(TICK_MAX_US);
      else dt = 15'(dtc);
   end

   // linear mapping operands
   always_comb begin
      den_lin = 17'(Q15_ONE) - 17'(lin_ff);
      if (den_lin < 17'(Q15_MILLI)) den_lin = 17'(Q15_MILLI);
      num_lin = (16'(absu_ff) > lin_ff) ? 16'(absu_ff) - lin_ff : 16'd0;
      if (17'(num_lin) > den_lin) num_lin = 16'(den_lin);
      span = $signed({2'b0, max_ff}) - $signed({2'b0, min_ff});
      dnum = '0; dden = 17'd1;
      if (cmd.div1_start) begin
         if (lowseg_ff) begin
            dnum = DIV_BITS'(min_ff * absu_ff); dden = 17'(lin_ff);
         end else begin
            dnum = DIV_BITS'(num_lin * (span < 0 ? 17'(-span) : 17'(span)));
            dden = den_lin;
         end
      end else begin
         dnum = DIV_BITS'({32'(req_ff) * 32'(dt_ff), 8'b0});
         dden = {1'b0, min_ff};
      end
   end

   mpds_div u_div (.clock(clock), .reset(reset), .start(cmd.div1_start | cmd.div2_start),
      .num(dnum), .den(dden), .busy(busy), .quo(quo));

   // request from first quotient
   always_comb begin
      if (lowseg_ff) req_s = 19'(quo[16:0]);
      else if (span < 0) req_s = $signed({3'b0, min_ff}) - $signed({2'b0, quo[16:0]});
      else req_s = $signed({3'b0, min_ff}) + $signed({2'b0, quo[16:0]});
      capv = {1'b0, cap_ff};
      if (capv < {1'b0, min_ff}) capv = {1'b0, min_ff};
      else if (capv > {1'b0, max_ff}) capv = {1'b0, max_ff};
      req_a = (req_s < 0) ? 17'd0 : 17'(req_s);
      if (near_ff && req_a > capv) req_a = capv;
      req_b = (req_a > {1'b0, max_ff}) ? {1'b0, max_ff} : req_a;
   end

   always_comb begin
      csum = {1'b0, charge_ff} + 33'(quo);
      if (quo[DIV_BITS-1:33] != '0 || csum[32]) csat = '1; else csat = csum[31:0];
      pwq = {pw_ff, 8'b0};
      prem_new = prem_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= 16'd9175; max_ff <= 16'd58982; db_ff <= 15'd1311; ls_ff <= 15'd3277;
         cap_ff <= 16'd27525; pw_ff <= 16'd5000; rc_ff <= 16'd5000;
         charge_ff <= '0; prem_ff <= '0; coast_ff <= '0; ldir_ff <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_MIN_DUTY: min_ff <= csr_data;
               CSR_MAX_DUTY: max_ff <= csr_data;
               CSR_DEADBAND: db_ff <= csr_data[14:0];
               CSR_LIN_START: ls_ff <= csr_data[14:0];
               CSR_NEAR_CAP: cap_ff <= csr_data;
               CSR_PULSE_W: pw_ff <= csr_data;
               CSR_REV_COAST: rc_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.load) begin
            absu_ff <= absu; neg_ff <= neg; near_ff <= req_near_balance; dt_ff <= dt;
            lin_ff <= (lin > 16'(Q15_ONE)) ? 16'(Q15_ONE) : lin;
            lowseg_ff <= (absu < lin) && (min_ff != 16'd0);
            if (req_operation || absu < db_ff) begin
               charge_ff <= '0; prem_ff <= '0; coast_ff <= '0; ldir_ff <= '0;
               duty_ff <= '0; mode_ff <= MODE_IDLE; early_ff <= 1'b1;
            end else if (ldir_ff != 2'd0 && ldir_ff != dirc) begin
               charge_ff <= '0; prem_ff <= '0;
               coast_ff <= (rc_ff > 16'(dt)) ? rc_ff - 16'(dt) : 16'd0;
               ldir_ff <= dirc; duty_ff <= '0; mode_ff <= MODE_REVERSE; early_ff <= 1'b1;
            end else if (coast_ff != 16'd0) begin
               ldir_ff <= dirc;
               coast_ff <= (coast_ff > 16'(dt)) ? coast_ff - 16'(dt) : 16'd0;
               duty_ff <= '0; mode_ff <= MODE_REVERSE; early_ff <= 1'b1;
            end else begin
               ldir_ff <= dirc; early_ff <= 1'b0;
            end
         end
         if (cmd.finish && !early_ff) begin
            if (!div2_ff) begin
               charge_ff <= '0; prem_ff <= '0;
               duty_ff <= neg_ff ? -$signed(req_ff) : $signed(req_ff);
               mode_ff <= MODE_CONT;
            end else begin
               if (prem_ff == 16'd0 && csat >= 32'(pwq)) begin
                  charge_ff <= csat - 32'(pwq);
                  if (pw_ff != 16'd0) begin
                     prem_ff <= (pw_ff > 16'(dt_ff)) ? pw_ff - 16'(dt_ff) : 16'd0;
                     duty_ff <= neg_ff ? -$signed({1'b0, min_ff}) : $signed({1'b0, min_ff});
                     mode_ff <= MODE_PULSE_ON;
                  end else begin
                     duty_ff <= '0; mode_ff <= MODE_PULSE_OFF;
                  end
               end else if (prem_new != 16'd0) begin
                  charge_ff <= csat;
                  prem_ff <= (prem_ff > 16'(dt_ff)) ? prem_ff - 16'(dt_ff) : 16'd0;
                  duty_ff <= neg_ff ? -$signed({1'b0, min_ff}) : $signed({1'b0, min_ff});
                  mode_ff <= MODE_PULSE_ON;
               end else begin
                  charge_ff <= csat; duty_ff <= '0; mode_ff <= MODE_PULSE_OFF;
               end
            end
         end
      end
   end

   // latch the request after the first divide
   always_ff @(posedge clock) begin
      if (!busy && !cmd.div1_start && !cmd.div2_start
          && !cmd.finish && !cmd.load && !early_ff && !div2_ff) begin
         req_ff <= req_b;
         div2_ff <= (min_ff != 16'd0) && (req_b < {1'b0, min_ff});
      end
      if (cmd.load) div2_ff <= 1'b0;
   end

   assign sts.early_done = early_ff;
   assign sts.need_div2 = div2_ff;
   assign sts.div_busy = busy;
   assign res_duty = duty_ff;
   assign res_mode = mode_ff;
endmodule
`default_nettype wire

### rtl/mpds_ctrl.sv
`default_nettype none
module mpds_ctrl (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   output logic in_ready,
   output logic out_valid,
   input  wire logic out_ready,
   output mpds_pkg::cmd_type cmd,
   input  wire mpds_pkg::sts_type sts
);
   import mpds_pkg::*;
   localparam logic [2:0] S_IDLE = 3'd0, S_CHK = 3'd1, S_D1 = 3'd2, S_REQ = 3'd3,
                          S_SEL = 3'd4, S_D2 = 3'd5, S_FIN = 3'd6, S_OUT = 3'd7;
   logic [2:0] st_ff, st_in;
   logic ov_ff, ov_in;

   always_comb begin
      st_in = st_ff; ov_in = ov_ff; cmd = '0;
      if (out_ready) ov_in = 1'b0;
      in_ready = (st_ff == S_IDLE) && !ov_ff;
      case (st_ff)
         S_IDLE: if (in_valid && in_ready) begin cmd.load = 1'b1; st_in = S_CHK; end
         S_CHK: begin
            if (sts.early_done) st_in = S_OUT;
            else begin cmd.div1_start = 1'b1; st_in = S_D1; end
         end
         S_D1: if (!sts.div_busy) st_in = S_REQ;
         S_REQ: st_in = S_SEL;
         S_SEL: begin
            if (sts.need_div2) begin cmd.div2_start = 1'b1; st_in = S_D2; end
            else st_in = S_FIN;
         end
         S_D2: if (!sts.div_busy) st_in = S_FIN;
         S_FIN: begin cmd.finish = 1'b1; st_in = S_OUT; end
         S_OUT: begin ov_in = 1'b1; st_in = S_IDLE; end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in; ov_ff <= ov_in;
      end
   end
   assign out_valid = ov_ff;
endmodule
`default_nettype wire

### rtl/motor_pulse_density_shaper.sv
`default_nettype none
// Motor pulse-density shaper, one wheel.
// Input channel req_*: one item per control tick (operation, command,
// near_balance, tick_us). Output channel rsp_*: one item per input item
// (signed duty Q0.16 and mode).
// csr_*: write-only register port, indexes 0..6, taken while idle: the user
// must keep to this, the block itself does not enforce it.
// Path: rsp_valid rises after states S_CHK and S_OUT when the item ends
// early (coast operation, deadband, reversal, running coast), else after
// S_CHK, one 40-step divide in S_D1, S_REQ, S_SEL, S_FIN and S_OUT, with a
// second divide in S_D2 when the request falls into pulse mode. The shared
// radix-2 divider yields one quotient bit per cycle.
// One item is handled at a time; req_ready is low while one is in work or
// while a result waits, and returns the cycle after the result is taken.
// Reset: registers return to their defaults, charge, burst, coast timers and
// direction are cleared, no result is pending.
// A stalled receiver holds rsp_valid and the result; no new item is taken.
module motor_pulse_density_shaper #(
   parameter int TICK_BITS = mpds_pkg::TICK_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic req_operation,
   input  wire logic signed [15:0] req_command,
   input  wire logic req_near_balance,
   input  wire logic [TICK_BITS-1:0] req_tick_us,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic signed [16:0] rsp_duty,
   output logic [2:0] rsp_mode,
   input  wire logic csr_write,
   input  wire logic [mpds_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [mpds_pkg::CSR_DATA_BITS-1:0] csr_data
);
   import mpds_pkg::*;
   cmd_type cmd;
   sts_type sts;

   mpds_ctrl u_ctrl (.clock(clock), .reset(reset), .in_valid(req_valid),
      .in_ready(req_ready), .out_valid(rsp_valid), .out_ready(rsp_ready),
      .cmd(cmd), .sts(sts));

   mpds_datapath #(.TICK_BITS(TICK_BITS)) u_dp (.clock(clock), .reset(reset),
      .cmd(cmd), .sts(sts), .csr_write(csr_write), .csr_index(csr_index),
      .csr_data(csr_data), .req_operation(req_operation), .req_command(req_command),
      .req_near_balance(req_near_balance), .req_tick_us(req_tick_us),
      .res_duty(rsp_duty), .res_mode(rsp_mode));

`ifndef NO_ASSERTIONS
   a_no_accept_while_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("item taken while result pending");
   a_mode_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_mode <= MODE_PULSE_OFF)) else $error("bad mode");
   a_zero_duty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_mode == MODE_IDLE || rsp_mode == MODE_REVERSE) |-> rsp_duty == 0)
      else $error("nonzero duty while idle or coasting");
`endif
endmodule
`default_nettype wire

### tb/motor_pulse_density_shaper_tb.sv
`default_nettype none
module motor_pulse_density_shaper_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mpds_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_operation = 1'b0;
   logic signed [15:0] req_command = '0;
   logic req_near_balance = 1'b0;
   logic [15:0] req_tick_us = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [16:0] rsp_duty;
   logic [2:0] rsp_mode;
   logic csr_write = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   motor_pulse_density_shaper dut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   typedef struct packed {
      logic [16:0] duty;
      logic [2:0] mode;
   } duty_out_type;

   typedef struct {
      logic op;
      logic [15:0] cmd;
      logic near;
      logic [15:0] tick;
      logic known;
      logic [16:0] duty;
      logic [2:0] mode;
   } shaper_row_type;

   // shadow registers and state
   int unsigned r_min, r_max, r_db, r_lin, r_cap, r_pw, r_rc;
   longint unsigned st_charge;
   int unsigned st_pulse, st_coast, st_dir;

   duty_out_type duty_due[$];
   int errors = 0;
   int items_sent = 0, results_seen = 0, configs_done = 0;
   bit tail_phase = 0;
   bit long_hold = 0;
   int idle_cycles = 0;

   function automatic duty_out_type pack_duty(int dir, longint mag, logic [2:0] md);
      duty_out_type o;
      longint v;
      v = (dir < 0) ? -mag : mag;
      o.duty = v[16:0];
      o.mode = md;
      return o;
   endfunction

   function automatic duty_out_type shape_duty(logic op, logic [15:0] cmd_raw, logic near,
                                               logic [15:0] tick_raw);
      longint dt, cmd, absu, lin, req, den, num, span, cap, inc, c, pw;
      int dir;
      int unsigned dirc;
      if (op) begin
         st_charge = 0; st_pulse = 0; st_coast = 0; st_dir = 0;
         return pack_duty(1, 0, MODE_IDLE);
      end
      dt = tick_raw;
      if (dt < TICK_MIN_US) dt = TICK_MIN_US;
      if (dt > TICK_MAX_US) dt = TICK_MAX_US;
      cmd = $signed(cmd_raw);
      if (cmd < -32767) cmd = -32767;
      absu = (cmd < 0) ? -cmd : cmd;
      lin = r_db + Q15_MILLI;
      if (r_lin > lin) lin = r_lin;
      if (lin > Q15_ONE) lin = Q15_ONE;
      if (absu < r_db) begin
         st_charge = 0; st_pulse = 0; st_coast = 0; st_dir = 0;
         return pack_duty(1, 0, MODE_IDLE);
      end
      dir = (cmd > 0) ? 1 : -1;
      dirc = (dir > 0) ? 1 : 2;
      if (st_dir != 0 && st_dir != dirc) begin
         st_charge = 0; st_pulse = 0;
         st_coast = (r_rc > dt) ? 32'(r_rc - dt) : 0;
         st_dir = dirc;
         return pack_duty(dir, 0, MODE_REVERSE);
      end
      st_dir = dirc;
      if (st_coast > 0) begin
         st_coast = (st_coast > dt) ? 32'(st_coast - dt) : 0;
         return pack_duty(dir, 0, MODE_REVERSE);
      end
      if (absu < lin && r_min > 0) begin
         req = (longint'(r_min) * absu) / lin;
      end else begin
         den = Q15_ONE - lin;
         num = absu - lin;
         span = longint'(r_max) - longint'(r_min);
         if (den < Q15_MILLI) den = Q15_MILLI;
         if (num < 0) num = 0;
         if (num > den) num = den;
         req = r_min + (num * span) / den;
      end
      if (near) begin
         cap = r_cap;
         if (cap < r_min) cap = r_min;
         else if (cap > r_max) cap = r_max;
         if (req > cap) req = cap;
      end
      if (req < 0) req = 0;
      if (req > r_max) req = r_max;
      if (r_min > 0 && req < r_min) begin
         inc = ((req * dt) << CHARGE_FRAC) / r_min;
         c = st_charge + inc;
         pw = longint'(r_pw) << CHARGE_FRAC;
         st_charge = (c > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : c;
         if (st_pulse == 0 && st_charge >= pw) begin
            st_charge = st_charge - pw;
            st_pulse = r_pw;
         end
         if (st_pulse > 0) begin
            st_pulse = (st_pulse > dt) ? 32'(st_pulse - dt) : 0;
            return pack_duty(dir, r_min, MODE_PULSE_ON);
         end
         return pack_duty(dir, 0, MODE_PULSE_OFF);
      end
      st_charge = 0; st_pulse = 0;
      return pack_duty(dir, req, MODE_CONT);
   endfunction

   task automatic write_reg(logic [2:0] idx, int unsigned val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val[15:0];
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_MIN_DUTY: r_min = val & 16'hFFFF;
         CSR_MAX_DUTY: r_max = val & 16'hFFFF;
         CSR_DEADBAND: r_db = val & 15'h7FFF;
         CSR_LIN_START: r_lin = val & 15'h7FFF;
         CSR_NEAR_CAP: r_cap = val & 16'hFFFF;
         CSR_PULSE_W: r_pw = val & 16'hFFFF;
         CSR_REV_COAST: r_rc = val & 16'hFFFF;
         default: ;
      endcase
      configs_done++;
   endtask

   task automatic drain_wait();
      req_valid <= 1'b0;
      while (duty_due.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic send_item(logic op, logic [15:0] cmd, logic near, logic [15:0] tick,
                            logic known, duty_out_type want);
      duty_out_type pred;
      if (!tail_phase && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_command <= cmd;
      req_near_balance <= near;
      req_tick_us <= tick;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pred = shape_duty(op, cmd, near, tick);
      if (known && pred !== want) begin
         $display("%0t table row disagrees with predictor: expected %h actual %h",
                  $time, want, pred);
         errors++;
      end
      if (known) pred = want;
      duty_due.push_back(pred);
      items_sent++;
   endtask

   task automatic set_config(int unsigned mn, int unsigned mx, int unsigned db,
                             int unsigned ls, int unsigned cp, int unsigned pw,
                             int unsigned rc);
      drain_wait();
      write_reg(CSR_MIN_DUTY, mn);
      write_reg(CSR_MAX_DUTY, mx);
      write_reg(CSR_DEADBAND, db);
      write_reg(CSR_LIN_START, ls);
      write_reg(CSR_NEAR_CAP, cp);
      write_reg(CSR_PULSE_W, pw);
      write_reg(CSR_REV_COAST, rc);
   endtask

   task automatic random_items(int n, bit small_cmds);
      logic [15:0] cmd, tick;
      int sgn;
      sgn = 1;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) == 0) sgn = -sgn;
         case ($urandom_range(0, 3))
            0: cmd = 16'($urandom);
            1: cmd = small_cmds ? 16'($urandom_range(0, 4000)) : 16'($urandom_range(0, 32767));
            default: cmd = 16'($urandom_range(0, 6000));
         endcase
         if (sgn < 0) cmd = -cmd;
         case ($urandom_range(0, 3))
            0: tick = 16'($urandom);
            default: tick = 16'($urandom_range(50, 21000));
         endcase
         send_item($urandom_range(0, 30) == 0, cmd, 1'($urandom_range(0, 1)), tick, 1'b0, '0);
      end
   endtask

   shaper_row_type table_rows[] = '{
      '{1'b1, 16'h0000, 1'b0, 16'd1000, 1'b1, 17'd0, MODE_IDLE},
      '{1'b0, 16'h0000, 1'b0, 16'd1000, 1'b1, 17'd0, MODE_IDLE},
      '{1'b0, 16'h7FFF, 1'b0, 16'd20000, 1'b1, 17'd58980, MODE_CONT},
      '{1'b0, 16'h7FFF, 1'b1, 16'd0, 1'b1, 17'd27525, MODE_CONT},
      '{1'b0, 16'h8000, 1'b0, 16'd1000, 1'b1, 17'd0, MODE_REVERSE},
      '{1'b0, 16'h8000, 1'b0, 16'hFFFF, 1'b1, 17'd0, MODE_REVERSE},
      '{1'b0, 16'h8000, 1'b0, 16'd1000, 1'b1, -17'sd58980, MODE_CONT},
      '{1'b0, 16'h8000, 1'b1, 16'd1000, 1'b0, '0, MODE_IDLE},
      '{1'b0, 16'd500, 1'b0, 16'd1000, 1'b1, 17'd0, MODE_IDLE},
      '{1'b0, 16'd2000, 1'b0, 16'd20000, 1'b0, '0, MODE_IDLE},
      '{1'b0, 16'd2000, 1'b0, 16'd20000, 1'b0, '0, MODE_IDLE},
      '{1'b0, 16'd2000, 1'b0, 16'd20000, 1'b0, '0, MODE_IDLE},
      '{1'b0, 16'd3277, 1'b0, 16'd100, 1'b0, '0, MODE_IDLE},
      '{1'b0, 16'd1400, 1'b0, 16'd5, 1'b0, '0, MODE_IDLE},
      '{1'b0, 16'd1400, 1'b1, 16'd20000, 1'b0, '0, MODE_IDLE},
      '{1'b0, 16'd1400, 1'b0, 16'd20000, 1'b0, '0, MODE_IDLE},
      '{1'b1, 16'h7FFF, 1'b1, 16'hFFFF, 1'b1, 17'd0, MODE_IDLE},
      '{1'b0, 16'hF000, 1'b0, 16'd300, 1'b0, '0, MODE_IDLE}
   };

   // result checker
   always @(posedge clock) begin
      duty_out_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (duty_due.size() == 0) begin
            $display("%0t unexpected item: duty %0d mode %0d", $time, rsp_duty, rsp_mode);
            errors++;
         end else begin
            want = duty_due.pop_front();
            results_seen++;
            if (rsp_duty !== want.duty) begin
               $display("%0t duty mismatch: expected %0d actual %0d", $time,
                        $signed(want.duty), rsp_duty);
               errors++;
            end
            if (rsp_mode !== want.mode) begin
               $display("%0t mode mismatch: expected %0d actual %0d", $time,
                        want.mode, rsp_mode);
               errors++;
            end
         end
      end
   end

   // receiver readiness
   initial begin
      int hold;
      @(negedge reset);
      forever begin
         if (long_hold) begin
            rsp_ready <= 1'b0;
            hold = 300;
            while (hold > 0) begin
               @(posedge clock);
               hold--;
            end
            long_hold = 0;
         end else if (!tail_phase && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t watchdog expired", $time);
         $display("motor_pulse_density_shaper verification failed");
         $finish;
      end
   end

   initial begin
      duty_out_type want;
      r_min = 9175; r_max = 58982; r_db = 1311; r_lin = 3277;
      r_cap = 27525; r_pw = 5000; r_rc = 5000;
      st_charge = 0; st_pulse = 0; st_coast = 0; st_dir = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (table_rows[i]) begin
         want.duty = table_rows[i].duty;
         want.mode = table_rows[i].mode;
         send_item(table_rows[i].op, table_rows[i].cmd, table_rows[i].near,
                   table_rows[i].tick, table_rows[i].known, want);
      end
      set_config(9175, 58982, 0, 0, 27525, 5000, 5000);
      send_item(1'b0, 16'h0000, 1'b0, 16'd1000, 1'b1, '{17'd0, MODE_PULSE_OFF});
      send_item(1'b0, 16'd10, 1'b0, 16'd1000, 1'b0, '0);
      drain_wait();
      write_reg(3'd7, 16'hFFFF);
      // receiver stall while the sender keeps offering
      long_hold = 1;
      random_items(20, 1'b0);
      drain_wait();
      random_items(250, 1'b1);
      set_config(0, 65535, 0, 32767, 0, 1, 0);
      random_items(120, 1'b0);
      set_config(65535, 0, 31130, 0, 65535, 65535, 65535);
      random_items(120, 1'b0);
      set_config(40000, 20000, 100, 200, 30000, 0, 300);
      random_items(120, 1'b1);
      set_config(200, 65535, 0, 32767, 100, 65535, 0);
      random_items(120, 1'b1);
      set_config($urandom_range(1, 20000), $urandom_range(20000, 65535),
                 $urandom_range(0, 3000), $urandom_range(0, 8000),
                 $urandom, $urandom_range(1, 8000), $urandom);
      random_items(200, 1'b1);
      tail_phase = 1;
      random_items(150, 1'b1);
      drain_wait();
      $display("Covered %0d items, %0d results checked, %0d register writes,",
               items_sent, results_seen, configs_done);
      $display("including reversals, deadband, pulse bursts and receiver stalls.");
      if (errors == 0 && duty_due.size() == 0) begin
         $display("motor_pulse_density_shaper verification clean");
      end else begin
         $display("motor_pulse_density_shaper verification failed");
      end
      $finish;
   end
endmodule
`default_nettype wire

### motor_pulse_density_shaper.f
rtl/mpds_pkg.sv
rtl/mpds_div.sv
rtl/mpds_datapath.sv
rtl/mpds_ctrl.sv
rtl/motor_pulse_density_shaper.sv
tb/motor_pulse_density_shaper_tb.sv
